FILE: hw/rtl/afc_pkg.sv
package afc_pkg;

	localparam int unsigned FIELD_W         = 32;
	localparam int unsigned COEF_W          = 32;
	localparam int unsigned PROD_W          = 2 * COEF_W;
	localparam int unsigned PAIR_W          = PROD_W + 1;
	localparam int unsigned CLIP_W          = PROD_W + 2;
	localparam int unsigned TEST_W          = CLIP_W + 1;
	localparam int unsigned NUM_AXES        = 3;
	localparam int unsigned NUM_ROWS        = 4;
	localparam int unsigned NUM_CORNERS     = 8;
	localparam int unsigned NUM_PLANES      = 6;
	localparam int unsigned NUM_REGS        = 8;
	localparam int unsigned REG_IDX_W       = $clog2(NUM_REGS);
	localparam int unsigned CFG_IDX_W       = REG_IDX_W + 1;
	localparam int unsigned CFG_W           = 2 * COEF_W;
	localparam int unsigned DEF_COORD_WIDTH = 32;
	localparam int unsigned DEF_FRAC_BITS   = 16;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [PAIR_W-1:0]  pair_t;
	typedef logic signed [CLIP_W-1:0]  clip_t;

	// stage enables handed to each row unit
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

FILE: hw/rtl/afc_row.sv
module afc_row #(
	parameter int unsigned FRAC_BITS = afc_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  afc_pkg::pipe_ctl_t ctl,
	input  afc_pkg::coef_t     coef   [afc_pkg::NUM_ROWS],
	input  afc_pkg::field_t    lo     [afc_pkg::NUM_AXES],
	input  afc_pkg::field_t    hi     [afc_pkg::NUM_AXES],
	output afc_pkg::clip_t     corner [afc_pkg::NUM_CORNERS]
);
	import afc_pkg::*;

	prod_t prod_lo_s1 [NUM_AXES];
	prod_t prod_hi_s1 [NUM_AXES];
	prod_t w_s1;
	pair_t xy_s2 [4];
	pair_t zw_s2 [2];
	clip_t corner_s3 [NUM_CORNERS];

	// s1: one product per axis and bound; w column is a plain shift
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_lo_s1[a] <= coef[a] * lo[a];
				prod_hi_s1[a] <= coef[a] * hi[a];
			end
			w_s1 <= PROD_W'(coef[NUM_ROWS-1]) <<< FRAC_BITS;
		end
	end

	// s2: x+y for the four x/y choices, z+w for the two z choices
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int i = 0; i < 4; i++) begin
				xy_s2[i] <= PAIR_W'(i[1] ? prod_hi_s1[0] : prod_lo_s1[0])
					+ PAIR_W'(i[0] ? prod_hi_s1[1] : prod_lo_s1[1]);
			end
			for (int j = 0; j < 2; j++) begin
				zw_s2[j] <= PAIR_W'(j[0] ? prod_hi_s1[2] : prod_lo_s1[2]) + PAIR_W'(w_s1);
			end
		end
	end

	// s3: corner k takes x from bit 2, y from bit 1, z from bit 0
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				corner_s3[k] <= CLIP_W'(xy_s2[k[2:1]]) + CLIP_W'(zw_s2[k[0]]);
			end
		end
	end

	assign corner = corner_s3;

endmodule

FILE: hw/rtl/aabb_frustum_cull_unit.sv
// Clip-space frustum cull of axis-aligned boxes.
// Box channel: box_valid/box_ready with min_x..max_z, signed Q16.16 (low
// COORD_WIDTH bits used, sign-extended). Result channel: res_valid/res_ready
// with visible and reject_planes (bit 0 -x, 1 +x, 2 -y, 3 +y, 4 -z, 5 +z).
// Configuration: cfg_we/cfg_index/cfg_wdata write one 64-bit matrix register
// per cycle, no wait; indices beyond the eight registers are ignored. Write
// only while the pipe is empty.
// Throughput: one box per cycle while the output is not stalled. A box
// passes four register stages (products, pair sums, corner sums, plane
// test and mask) before its result is valid.
// Reset clears the valid bits and loads the identity matrix.
// A stalled result holds in the output stage; earlier stages keep taking
// boxes until each holds an item, then box_ready drops. Nothing is lost
// or repeated across a stall.
module aabb_frustum_cull_unit #(
	parameter int unsigned COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH,
	parameter int unsigned FRAC_BITS   = afc_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afc_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             box_valid,
	output logic                             box_ready,
	input  afc_pkg::field_t                  min_x,
	input  afc_pkg::field_t                  min_y,
	input  afc_pkg::field_t                  min_z,
	input  afc_pkg::field_t                  max_x,
	input  afc_pkg::field_t                  max_y,
	input  afc_pkg::field_t                  max_z,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic                             visible,
	output logic [afc_pkg::NUM_PLANES-1:0]   reject_planes
);
	import afc_pkg::*;

	localparam int unsigned CW_SHIFT = FIELD_W - COORD_WIDTH;

	// identity: 1.0 on the diagonal; register i holds row i/2, columns
	// 2*(i%2) (low half) and 2*(i%2)+1 (high half)
	function automatic logic [CFG_W-1:0] reg_reset(int unsigned idx);
		int unsigned      row;
		int unsigned      col0;
		logic [CFG_W-1:0] r;
		row  = idx >> 1;
		col0 = (idx & 1) << 1;
		r    = '0;
		if (row == col0) begin
			r[COEF_W-1:0] = COEF_W'(1) << FRAC_BITS;
		end
		if (row == col0 + 1) begin
			r[CFG_W-1:COEF_W] = COEF_W'(1) << FRAC_BITS;
		end
		return r;
	endfunction

	function automatic field_t sext_coord(field_t v);
		field_t t;
		t = v <<< CW_SHIFT;
		return t >>> CW_SHIFT;
	endfunction

	logic [CFG_W-1:0] cfg_q [NUM_REGS];
	coef_t            coef [NUM_ROWS][NUM_ROWS];
	field_t           lo [NUM_AXES];
	field_t           hi [NUM_AXES];
	clip_t            clip [NUM_ROWS][NUM_CORNERS];

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s4;
	pipe_ctl_t ctl;

	logic [NUM_PLANES-1:0] mask;
	logic [NUM_PLANES-1:0] reject_s4;
	logic                  visible_s4;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= reg_reset(i);
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			cfg_q[cfg_index[REG_IDX_W-1:0]] <= cfg_wdata;
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_coef_r
		for (genvar c = 0; c < NUM_ROWS; c++) begin : g_coef_c
			assign coef[r][c] = cfg_q[2*r + c/2][COEF_W*(c%2) +: COEF_W];
		end
	end

	assign lo[0] = sext_coord(min_x);
	assign lo[1] = sext_coord(min_y);
	assign lo[2] = sext_coord(min_z);
	assign hi[0] = sext_coord(max_x);
	assign hi[1] = sext_coord(max_y);
	assign hi[2] = sext_coord(max_z);

	// each stage advances when empty or when the next one advances
	assign en_s4     = !valid_s4 || res_ready;
	assign ctl.en_s3 = !valid_s3 || en_s4;
	assign ctl.en_s2 = !valid_s2 || ctl.en_s3;
	assign ctl.en_s1 = !valid_s1 || ctl.en_s2;
	assign box_ready = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				valid_s1 <= box_valid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// one row unit per clip coordinate: x, y, z, w
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		afc_row #(
			.FRAC_BITS (FRAC_BITS)
		) u_row (
			.clk    (clk),
			.ctl    (ctl),
			.coef   (coef[r]),
			.lo     (lo),
			.hi     (hi),
			.corner (clip[r])
		);
	end

	// plane test: below when v + w < 0, above when w - v < 0 (strict, so a
	// corner on a plane is inside). A plane rejects only if all corners agree.
	always_comb begin
		logic signed [TEST_W-1:0] t_below;
		logic signed [TEST_W-1:0] t_above;
		logic [NUM_PLANES-1:0]    outside;
		mask = '1;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			outside = '0;
			for (int r = 0; r < NUM_AXES; r++) begin
				t_below = TEST_W'(clip[r][k]) + TEST_W'(clip[NUM_ROWS-1][k]);
				t_above = TEST_W'(clip[NUM_ROWS-1][k]) - TEST_W'(clip[r][k]);
				outside[2*r]     = t_below[TEST_W-1];
				outside[2*r + 1] = t_above[TEST_W-1];
			end
			mask = mask & outside;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			reject_s4  <= mask;
			visible_s4 <= (mask == '0);
		end
	end

	assign res_valid     = valid_s4;
	assign visible       = visible_s4;
	assign reject_planes = reject_s4;

endmodule

FILE: hw/rtl/afc_checker.sv
module afc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           box_valid,
	input logic                           box_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic                           visible,
	input logic [afc_pkg::NUM_PLANES-1:0] reject_planes
);
	import afc_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(visible) && $stable(reject_planes))
		else $error("stalled result changed");

	// visible is set exactly when no plane rejects
	a_vis_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (visible == (reject_planes == '0)))
		else $error("visible disagrees with reject_planes");

	// back-pressure only comes from a stalled output
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> box_ready)
		else $error("box_ready low while results drain");

	// an accepted box reaches res_valid while the receiver keeps res_ready high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_ready ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)
		else $error("result missing four cycles after accept");

endmodule

bind aabb_frustum_cull_unit afc_checker u_afc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.box_valid     (box_valid),
	.box_ready     (box_ready),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.visible       (visible),
	.reject_planes (reject_planes)
);

FILE: tb/aabb_frustum_cull_checker.sv
`timescale 1ns / 100ps

module aabb_frustum_cull_checker #(
	parameter int unsigned COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH,
	parameter int unsigned FRAC_BITS   = afc_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afc_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             box_valid,
	input  logic                             box_ready,
	input  afc_pkg::field_t                  min_x,
	input  afc_pkg::field_t                  min_y,
	input  afc_pkg::field_t                  min_z,
	input  afc_pkg::field_t                  max_x,
	input  afc_pkg::field_t                  max_y,
	input  afc_pkg::field_t                  max_z,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  logic                             visible,
	input  logic [afc_pkg::NUM_PLANES-1:0]   reject_planes,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);
	import afc_pkg::*;

	// wide enough for any product or sum of the clip transform
	localparam int unsigned WIDE_W = 128;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic                  visible;
		logic [NUM_PLANES-1:0] reject_planes;
	} cull_verdict_t;

	coef_t         vp_coef [NUM_ROWS][NUM_ROWS];
	cull_verdict_t verdict_q [$];
	int unsigned   errs = 0;
	int unsigned   reported = 0;

	function automatic wide_t coord_ext(input field_t v);
		wide_t t;
		t = v;
		t = t <<< (WIDE_W - COORD_WIDTH);
		return t >>> (WIDE_W - COORD_WIDTH);
	endfunction

	function automatic cull_verdict_t predict_cull(input field_t mn_x, input field_t mn_y,
			input field_t mn_z, input field_t mx_x, input field_t mx_y, input field_t mx_z);
		wide_t lo [NUM_AXES];
		wide_t hi [NUM_AXES];
		wide_t pt [NUM_ROWS];
		wide_t clip [NUM_ROWS];
		wide_t coef;
		logic [NUM_PLANES-1:0] outside;
		logic [NUM_PLANES-1:0] common;
		cull_verdict_t v;
		int k, r, c;
		lo[0] = coord_ext(mn_x);
		lo[1] = coord_ext(mn_y);
		lo[2] = coord_ext(mn_z);
		hi[0] = coord_ext(mx_x);
		hi[1] = coord_ext(mx_y);
		hi[2] = coord_ext(mx_z);
		common = '1;
		for (k = 0; k < NUM_CORNERS; k++) begin
			pt[0] = ((k & 4) != 0) ? hi[0] : lo[0];
			pt[1] = ((k & 2) != 0) ? hi[1] : lo[1];
			pt[2] = ((k & 1) != 0) ? hi[2] : lo[2];
			pt[3] = 1;
			pt[3] = pt[3] <<< FRAC_BITS;
			for (r = 0; r < NUM_ROWS; r++) begin
				clip[r] = '0;
				for (c = 0; c < NUM_ROWS; c++) begin
					coef = vp_coef[r][c];
					clip[r] = clip[r] + coef * pt[c];
				end
			end
			// strict tests only: a corner on a plane is inside
			outside = '0;
			for (r = 0; r < NUM_AXES; r++) begin
				if (clip[r] + clip[3] < 0)
					outside[2*r] = 1'b1;
				if (clip[3] - clip[r] < 0)
					outside[2*r+1] = 1'b1;
			end
			common &= outside;
		end
		v.reject_planes = common;
		v.visible = (common == '0);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int r, c, row, col;
		cull_verdict_t want;
		if (!arst_n) begin
			for (r = 0; r < NUM_ROWS; r++)
				for (c = 0; c < NUM_ROWS; c++)
					vp_coef[r][c] = (r == c) ? coef_t'(1 << FRAC_BITS) : '0;
			verdict_q.delete();
			pending <= 0;
			fail_count <= errs;
		end else begin
			if (res_valid && res_ready) begin
				if (verdict_q.size() == 0) begin
					errs++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result item: visible=%0b planes=%06b",
							visible, reject_planes);
					end
				end else begin
					want = verdict_q.pop_front();
					if (want.visible !== visible || want.reject_planes !== reject_planes) begin
						errs++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: expected visible=%0b planes=%06b, got visible=%0b planes=%06b",
								want.visible, want.reject_planes, visible, reject_planes);
						end
					end
				end
			end
			if (box_valid && box_ready)
				verdict_q.push_back(predict_cull(min_x, min_y, min_z, max_x, max_y, max_z));
			// indices past the register file are dropped
			if (cfg_we && cfg_index < NUM_REGS) begin
				row = cfg_index >> 1;
				col = (cfg_index & 1) * 2;
				vp_coef[row][col]     = cfg_wdata[COEF_W-1:0];
				vp_coef[row][col + 1] = cfg_wdata[CFG_W-1:COEF_W];
			end
			pending <= verdict_q.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: tb/aabb_frustum_cull_unit_tb.sv
`timescale 1ns / 100ps

module aabb_frustum_cull_unit_tb;
	import afc_pkg::*;

	localparam int unsigned COORD_WIDTH     = DEF_COORD_WIDTH;
	localparam int unsigned FRAC_BITS       = DEF_FRAC_BITS;
	localparam int          ONE             = 1 << FRAC_BITS;
	localparam int          COORD_MIN       = 32'sh80000000;
	localparam int          COORD_MAX       = 32'sh7FFFFFFF;
	localparam coef_t       COEF_MIN        = 32'sh80000000;
	localparam coef_t       COEF_MAX        = 32'sh7FFFFFFF;
	localparam int unsigned NUM_PHASES      = 8;
	localparam int unsigned ITEMS_PER_PHASE = 180;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned DRAIN_CYCLES    = 8;    // four-stage pipe plus margin
	localparam int unsigned CYCLE_LIMIT     = 300000;

	// matrix register file, index i is register i
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VP_R0_C01 = 0,
		REG_VP_R0_C23 = 1,
		REG_VP_R1_C01 = 2,
		REG_VP_R1_C23 = 3,
		REG_VP_R2_C01 = 4,
		REG_VP_R2_C23 = 5,
		REG_VP_R3_C01 = 6,
		REG_VP_R3_C23 = 7
	} vp_reg_e;

	// matrix flavour loaded for each random phase
	typedef enum int {
		MAT_SMALL,
		MAT_IDENTITY,
		MAT_FULL,
		MAT_PERSPECTIVE,
		MAT_ALL_MIN,
		MAT_ALL_MAX,
		MAT_ZERO,
		MAT_MIXED_EXTREME
	} matrix_kind_e;

	// receiver stall patterns
	typedef enum int {
		SINK_FREE,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_e;

	typedef struct packed {
		field_t min_x;
		field_t min_y;
		field_t min_z;
		field_t max_x;
		field_t max_y;
		field_t max_z;
	} box_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  box_valid;
	logic                  box_ready;
	field_t                min_x;
	field_t                min_y;
	field_t                min_z;
	field_t                max_x;
	field_t                max_y;
	field_t                max_z;
	logic                  res_valid;
	logic                  res_ready;
	logic                  visible;
	logic [NUM_PLANES-1:0] reject_planes;
	int unsigned           fail_count;
	int unsigned           pending;

	logic [CFG_W-1:0]      vp_image [NUM_REGS];  // matrix to be loaded next
	bit                    start_squeeze;        // asks the receiver for its long hold-off
	int unsigned           burst_left;
	int unsigned           cycle_count;

	aabb_frustum_cull_unit #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.box_valid     (box_valid),
		.box_ready     (box_ready),
		.min_x         (min_x),
		.min_y         (min_y),
		.min_z         (min_z),
		.max_x         (max_x),
		.max_y         (max_y),
		.max_z         (max_z),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.visible       (visible),
		.reject_planes (reject_planes)
	);

	aabb_frustum_cull_checker #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.box_valid     (box_valid),
		.box_ready     (box_ready),
		.min_x         (min_x),
		.min_y         (min_y),
		.min_z         (min_z),
		.max_x         (max_x),
		.max_y         (max_y),
		.max_z         (max_z),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.visible       (visible),
		.reject_planes (reject_planes),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	initial begin : watchdog
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[aabb_frustum_cull_unit] ERROR");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------------
	// helpers
	// --------------------------------------------------------------------

	function automatic box_t mk_box(input int lx, input int ly, input int lz,
			input int hx, input int hy, input int hz);
		box_t b;
		b.min_x = lx;
		b.min_y = ly;
		b.min_z = lz;
		b.max_x = hx;
		b.max_y = hy;
		b.max_z = hz;
		return b;
	endfunction

	// column 0 (or 2) in the low half, column 1 (or 3) in the high half
	function automatic logic [CFG_W-1:0] pack_pair(input coef_t c_lo, input coef_t c_hi);
		return {c_hi, c_lo};
	endfunction

	// coefficients within +-3.0, where culls and passes are both common
	function automatic coef_t coef_small();
		return int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
	endfunction

	function automatic coef_t coef_extreme();
		case ($urandom_range(0, 5))
			0:       return COEF_MIN;
			1:       return COEF_MAX;
			2:       return '0;
			3:       return -1;
			4:       return 1;
			default: return ONE;
		endcase
	endfunction

	function automatic int edge_value();
		case ($urandom_range(0, 5))
			0:       return ONE;
			1:       return -ONE;
			2:       return COORD_MIN;
			3:       return COORD_MAX;
			4:       return 0;
			default: return ONE + 1;
		endcase
	endfunction

	// mostly compact boxes around the unit cube, some raw 32-bit noise,
	// some swapped min/max and some with a coordinate pinned to an edge value
	function automatic box_t rand_box();
		box_t b;
		int unsigned pick;
		int cx, cy, cz, ex, ey, ez;
		field_t t;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			return mk_box($urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom());
		cx = int'($urandom_range(0, 7 * ONE)) - 7 * ONE / 2;
		cy = int'($urandom_range(0, 7 * ONE)) - 7 * ONE / 2;
		cz = int'($urandom_range(0, 7 * ONE)) - 7 * ONE / 2;
		ex = $urandom_range(0, ONE / 2);
		ey = $urandom_range(0, ONE / 2);
		ez = $urandom_range(0, ONE / 2);
		b = mk_box(cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez);
		if (pick == 3) begin
			t = b.min_x;
			b.min_x = b.max_x;
			b.max_x = t;
		end else if (pick < 7) begin
			case ($urandom_range(0, 5))
				0:       b.min_x = edge_value();
				1:       b.min_y = edge_value();
				2:       b.min_z = edge_value();
				3:       b.max_x = edge_value();
				4:       b.max_y = edge_value();
				default: b.max_z = edge_value();
			endcase
		end
		return b;
	endfunction

	function automatic void build_matrix(input matrix_kind_e kind);
		int i;
		for (i = 0; i < NUM_REGS; i++) begin
			case (kind)
				MAT_SMALL, MAT_PERSPECTIVE:
					vp_image[i] = pack_pair(coef_small(), coef_small());
				MAT_FULL:          vp_image[i] = {$urandom(), $urandom()};
				MAT_ALL_MIN:       vp_image[i] = pack_pair(COEF_MIN, COEF_MIN);
				MAT_ALL_MAX:       vp_image[i] = pack_pair(COEF_MAX, COEF_MAX);
				MAT_MIXED_EXTREME: vp_image[i] = pack_pair(coef_extreme(), coef_extreme());
				default:           vp_image[i] = '0;
			endcase
		end
		if (kind == MAT_IDENTITY) begin
			vp_image[REG_VP_R0_C01] = pack_pair(ONE, '0);
			vp_image[REG_VP_R1_C01] = pack_pair('0, ONE);
			vp_image[REG_VP_R2_C23] = pack_pair(ONE, '0);
			vp_image[REG_VP_R3_C23] = pack_pair('0, ONE);
		end else if (kind == MAT_PERSPECTIVE) begin
			// w = -z, as in a standard projection
			vp_image[REG_VP_R3_C01] = '0;
			vp_image[REG_VP_R3_C23] = pack_pair(-ONE, '0);
		end
	endfunction

	// --------------------------------------------------------------------
	// drivers
	// --------------------------------------------------------------------

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Writes the whole register file from vp_image. A stray write to a live
	// register may go first (it is overwritten), and writes to indices past
	// the register file are sprinkled in; those must change nothing.
	task automatic load_matrix();
		int i;
		if ($urandom_range(0, 1) == 1)
			write_reg(CFG_IDX_W'($urandom_range(0, NUM_REGS - 1)), {$urandom(), $urandom()});
		for (i = 0; i < NUM_REGS; i++) begin
			write_reg(CFG_IDX_W'(i), vp_image[i]);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
					{$urandom(), $urandom()});
		end
		write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
			{$urandom(), $urandom()});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one box and hold it until it is taken. Valid is left high so the
	// next item can follow back to back; pace() decides whether to drop it.
	task automatic push_box(input box_t b);
		box_valid <= 1'b1;
		min_x     <= b.min_x;
		min_y     <= b.min_y;
		min_z     <= b.min_z;
		max_x     <= b.max_x;
		max_y     <= b.max_y;
		max_z     <= b.max_z;
		@(posedge clk);
		while (!box_ready)
			@(posedge clk);
	endtask

	// sender bursts: random length, random gap after each
	task automatic pace();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			box_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 47);
		end
	endtask

	// Drop valid, wait for every outstanding result, then let the pipe run
	// dry so that a stray result would still be seen before moving on.
	task automatic settle();
		box_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// --------------------------------------------------------------------
	// result receiver: its own stall pattern plus one long hold-off, which
	// lets the pipe fill and forces box_ready low under a waiting sender
	// --------------------------------------------------------------------
	initial begin : result_sink
		sink_mode_e  mode;
		int unsigned mode_left, hold_left, tick;
		bit          squeeze_done;
		res_ready <= 1'b0;
		mode = SINK_FREE;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		squeeze_done = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (start_squeeze && !squeeze_done) begin
				hold_left = HOLD_CYCLES;
				squeeze_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = sink_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				case (mode)
					SINK_FREE:   res_ready <= 1'b1;
					SINK_COIN:   res_ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
					default:     res_ready <= ((tick % 5) < 3);
				endcase
			end
		end
	end

	// --------------------------------------------------------------------
	// stimulus and verdict
	// --------------------------------------------------------------------
	initial begin : stimulus
		int unsigned p, n;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		box_valid     <= 1'b0;
		min_x         <= '0;
		min_y         <= '0;
		min_z         <= '0;
		max_x         <= '0;
		max_y         <= '0;
		max_z         <= '0;
		arst_n        <= 1'b0;
		start_squeeze = 1'b0;
		burst_left    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed boxes against the reset matrix (identity): one box fully
		// inside, one beyond each plane, corners exactly on a plane, a hair
		// past it, min above max, two planes at once and the field extremes.
		push_box(mk_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2));
		push_box(mk_box(-3 * ONE, 0, 0, -2 * ONE, 0, 0));
		push_box(mk_box(2 * ONE, 0, 0, 3 * ONE, 0, 0));
		push_box(mk_box(0, -3 * ONE, 0, 0, -2 * ONE, 0));
		push_box(mk_box(0, 2 * ONE, 0, 0, 3 * ONE, 0));
		push_box(mk_box(0, 0, -3 * ONE, 0, 0, -2 * ONE));
		pace();
		push_box(mk_box(0, 0, 2 * ONE, 0, 0, 3 * ONE));
		push_box(mk_box(ONE, 0, 0, ONE, 0, 0));
		push_box(mk_box(0, -ONE, 0, 0, -ONE, 0));
		push_box(mk_box(0, 0, ONE, 0, 0, ONE));
		push_box(mk_box(ONE + 1, 0, 0, ONE + 1, 0, 0));
		push_box(mk_box(2 * ONE, 0, 0, -2 * ONE, 0, 0));
		pace();
		push_box(mk_box(0, 0, 3 * ONE, 0, 0, 2 * ONE));
		push_box(mk_box(2 * ONE, -3 * ONE, 0, 3 * ONE, -2 * ONE, 0));
		push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		push_box(mk_box(0, 0, 0, 0, 0, 0));
		settle();

		// Random phases, each under a freshly loaded matrix. The long receiver
		// hold-off is requested at item 60 of the full-range phase.
		for (p = 0; p < NUM_PHASES; p++) begin
			build_matrix(matrix_kind_e'(p));
			load_matrix();
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (matrix_kind_e'(p) == MAT_FULL && n == 60)
					start_squeeze = 1'b1;
				push_box(rand_box());
				pace();
			end
			settle();
		end

		if (fail_count == 0)
			$display("[aabb_frustum_cull_unit] OK");
		else
			$display("[aabb_frustum_cull_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/afc_pkg.sv
hw/rtl/afc_row.sv
hw/rtl/aabb_frustum_cull_unit.sv
hw/rtl/afc_checker.sv
tb/aabb_frustum_cull_checker.sv
tb/aabb_frustum_cull_unit_tb.sv
